@@ src/tlfbc_pkg.sv @@
// Shared constants, payload types and helpers for the two-level free buffer cache.
package tlfbc_pkg;

  localparam int NUM_CLASSES     = 32;
  localparam int MAX_CACHE_DEPTH = 256;
  localparam int HANDLE_BITS     = 32;

  localparam int CLASS_FIELD_BITS = 5;
  localparam int LIMIT_BITS       = 9;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CNT_BITS         = 32;

  localparam int CLASS_BITS   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CLS_EXT_BITS = (CLASS_BITS > CLASS_FIELD_BITS) ? CLASS_BITS : CLASS_FIELD_BITS;
  localparam int DEPTH_BITS   = $clog2(MAX_CACHE_DEPTH);
  localparam int FILL_BITS    = $clog2(MAX_CACHE_DEPTH + 1);
  localparam int LIM_EXT_BITS = (LIMIT_BITS > FILL_BITS) ? LIMIT_BITS : FILL_BITS;
  localparam int STACK_BITS   = CLASS_BITS + DEPTH_BITS;
  localparam int STACK_WORDS  = NUM_CLASSES << DEPTH_BITS;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCAL_LIMIT  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLOBAL_LIMIT = CFG_INDEX_BITS'(1);

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2);

  // Route codes
  localparam logic [1:0] ROUTE_LOCAL  = 2'd0;
  localparam logic [1:0] ROUTE_GLOBAL = 2'd1;
  localparam logic [1:0] ROUTE_POOL   = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic [CLASS_FIELD_BITS-1:0] size_class;
    logic [31:0]                 buffer_handle;
  } tlfbc_req_t;

  typedef struct packed {
    logic [31:0] result_handle;
    logic [1:0]  route;
    logic [31:0] local_alloc_total;
    logic [31:0] local_alloc_misses;
    logic [31:0] local_free_total;
    logic [31:0] local_free_misses;
    logic [31:0] global_alloc_total;
    logic [31:0] global_alloc_misses;
    logic [31:0] global_free_total;
    logic [31:0] global_free_misses;
  } tlfbc_rsp_t;

  // Four counters of one class in one memory row
  typedef struct packed {
    logic [CNT_BITS-1:0] alloc_total;
    logic [CNT_BITS-1:0] alloc_misses;
    logic [CNT_BITS-1:0] free_total;
    logic [CNT_BITS-1:0] free_misses;
  } tlfbc_cnt_row_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture request, issue memory reads
    logic commit;  // update stacks, fills, counters; load output word
  } tlfbc_cmd_t;

  // Depth limits above the stack size act as the stack size.
  function automatic logic [FILL_BITS-1:0] clamp_limit(input logic [LIMIT_BITS-1:0] lim);
    logic [LIM_EXT_BITS-1:0] ext;
    ext = LIM_EXT_BITS'(lim);
    if (ext > LIM_EXT_BITS'(MAX_CACHE_DEPTH)) begin
      return FILL_BITS'(MAX_CACHE_DEPTH);
    end
    return FILL_BITS'(ext);
  endfunction

endpackage

@@ src/two_level_free_buffer_cache_core.sv @@
// Top level of the two-level free buffer cache: controller plus datapath.
//
// Each size class keeps a local and a global LIFO stack of free buffer handles.
// in channel (in_valid/in_ready/in_data): one request word, allocate or free.
// out channel (out_valid/out_ready/out_data): one result word per request with
// the handle, the route (local, global, backing pool) and the eight counters
// of the addressed class, read after the update.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the local and
// global depth limits; ready whenever reset is low, write only while idle.
//
// Timing: the accept edge captures the word and issues the synchronous
// reads of both stacks and both counter rows; the commit edge of the execute
// state does the read-modify-write, loads the output register and raises
// out_valid. Requests do not overlap: in_ready is low in the execute state,
// so each request finishes its read-then-write on the stack and counter
// memories before the next request word is taken.
// A new request is taken while a finished result still waits in the output
// register; if the receiver stalls, the next request holds in its execute
// cycle until the output register frees up.
// Reset: clears fill counts, counter row valid bits and both limits (to 2) at
// once; stack contents are left as they are. in_ready and cfg_ready stay low.
module two_level_free_buffer_cache_core
  import tlfbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tlfbc_req_t                in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tlfbc_rsp_t                out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LIMIT_BITS-1:0]     cfg_data
);

  tlfbc_cmd_t cmd;

  // Limits are plain registers: take every write at once outside reset
  assign cfg_ready = !rst;

  tlfbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tlfbc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

@@ src/tlfbc_ctrl.sv @@
// Controller: sequences read and commit phases and owns the output valid flag.
module tlfbc_ctrl
  import tlfbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output tlfbc_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   can_commit;

  assign in_ready   = (state == ST_IDLE) && !rst;
  assign can_commit = (state == ST_EXEC) && (!out_valid || out_ready);

  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = can_commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (can_commit) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/tlfbc_datapath.sv @@
// Datapath: handle stacks, fill counts, counter rows, depth limits and output word.
module tlfbc_datapath
  import tlfbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  tlfbc_cmd_t                cmd,
  input  tlfbc_req_t                in_data,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LIMIT_BITS-1:0]     cfg_data,
  output tlfbc_rsp_t                out_data
);

  // Storage
  logic [HANDLE_BITS-1:0] local_stack  [STACK_WORDS];
  logic [HANDLE_BITS-1:0] global_stack [STACK_WORDS];
  tlfbc_cnt_row_t         local_cnt    [NUM_CLASSES];
  tlfbc_cnt_row_t         global_cnt   [NUM_CLASSES];
  logic [FILL_BITS-1:0]   local_fill   [NUM_CLASSES];
  logic [FILL_BITS-1:0]   global_fill  [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] cnt_valid;
  logic [LIMIT_BITS-1:0]  local_limit;
  logic [LIMIT_BITS-1:0]  global_limit;

  // Request registers and read data
  tlfbc_req_t             req;
  logic                   req_in_range;
  logic [HANDLE_BITS-1:0] local_rd;
  logic [HANDLE_BITS-1:0] global_rd;
  tlfbc_cnt_row_t         local_row_rd;
  tlfbc_cnt_row_t         global_row_rd;

  // Read address phase
  logic [CLS_EXT_BITS-1:0] in_cls_ext;
  logic [CLASS_BITS-1:0]   in_idx;
  logic [FILL_BITS-1:0]    in_lfill_dec;
  logic [FILL_BITS-1:0]    in_gfill_dec;
  logic [STACK_BITS-1:0]   local_rd_addr;
  logic [STACK_BITS-1:0]   global_rd_addr;

  assign in_cls_ext     = CLS_EXT_BITS'(in_data.size_class);
  assign in_idx         = in_cls_ext[CLASS_BITS-1:0];
  assign in_lfill_dec   = local_fill[in_idx] - FILL_BITS'(1);
  assign in_gfill_dec   = global_fill[in_idx] - FILL_BITS'(1);
  assign local_rd_addr  = {in_idx, in_lfill_dec[DEPTH_BITS-1:0]};
  assign global_rd_addr = {in_idx, in_gfill_dec[DEPTH_BITS-1:0]};

  // Execute phase
  logic [CLS_EXT_BITS-1:0] cls_ext;
  logic [CLASS_BITS-1:0]   idx;
  logic [HANDLE_BITS-1:0]  handle;
  logic [FILL_BITS-1:0]    lfill;
  logic [FILL_BITS-1:0]    gfill;
  logic [FILL_BITS-1:0]    lfill_next;
  logic [FILL_BITS-1:0]    gfill_next;
  tlfbc_cnt_row_t          lc;
  tlfbc_cnt_row_t          gc;
  tlfbc_cnt_row_t          lc_next;
  tlfbc_cnt_row_t          gc_next;
  logic                    local_push;
  logic                    global_push;
  logic [HANDLE_BITS-1:0]  res_handle;
  logic [1:0]              route;
  logic [STACK_BITS-1:0]   local_wr_addr;
  logic [STACK_BITS-1:0]   global_wr_addr;
  tlfbc_rsp_t              pool_rsp;

  assign cls_ext        = CLS_EXT_BITS'(req.size_class);
  assign idx            = cls_ext[CLASS_BITS-1:0];
  assign handle         = HANDLE_BITS'(req.buffer_handle);
  assign lfill          = local_fill[idx];
  assign gfill          = global_fill[idx];
  assign lc             = cnt_valid[idx] ? local_row_rd : '0;
  assign gc             = cnt_valid[idx] ? global_row_rd : '0;
  assign local_wr_addr  = {idx, lfill[DEPTH_BITS-1:0]};
  assign global_wr_addr = {idx, gfill[DEPTH_BITS-1:0]};

  always_comb begin
    lc_next     = lc;
    gc_next     = gc;
    lfill_next  = lfill;
    gfill_next  = gfill;
    local_push  = 1'b0;
    global_push = 1'b0;
    res_handle  = '0;
    route       = ROUTE_POOL;
    if (req.req_type == REQ_ALLOC) begin
      lc_next.alloc_total = lc.alloc_total + CNT_BITS'(1);
      if (lfill != '0) begin
        lfill_next = lfill - FILL_BITS'(1);
        res_handle = local_rd;
        route      = ROUTE_LOCAL;
      end else begin
        lc_next.alloc_misses = lc.alloc_misses + CNT_BITS'(1);
        gc_next.alloc_total  = gc.alloc_total + CNT_BITS'(1);
        if (gfill != '0) begin
          gfill_next = gfill - FILL_BITS'(1);
          res_handle = global_rd;
          route      = ROUTE_GLOBAL;
        end else begin
          gc_next.alloc_misses = gc.alloc_misses + CNT_BITS'(1);
        end
      end
    end else begin
      lc_next.free_total = lc.free_total + CNT_BITS'(1);
      if (lfill < clamp_limit(local_limit)) begin
        local_push = 1'b1;
        lfill_next = lfill + FILL_BITS'(1);
        route      = ROUTE_LOCAL;
      end else begin
        lc_next.free_misses = lc.free_misses + CNT_BITS'(1);
        gc_next.free_total  = gc.free_total + CNT_BITS'(1);
        if (gfill < clamp_limit(global_limit)) begin
          global_push = 1'b1;
          gfill_next  = gfill + FILL_BITS'(1);
          route       = ROUTE_GLOBAL;
        end else begin
          gc_next.free_misses = gc.free_misses + CNT_BITS'(1);
          res_handle          = handle;
        end
      end
    end
  end

  // Class beyond the table: pool route, handle echoed on a free, zero counters
  always_comb begin
    pool_rsp               = '0;
    pool_rsp.route         = ROUTE_POOL;
    pool_rsp.result_handle = (req.req_type == REQ_FREE) ? 32'(handle) : 32'd0;
  end

  // Capture request and issue reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req           <= in_data;
      req_in_range  <= (int'(in_cls_ext) < NUM_CLASSES);
      local_rd      <= local_stack[local_rd_addr];
      global_rd     <= global_stack[global_rd_addr];
      local_row_rd  <= local_cnt[in_idx];
      global_row_rd <= global_cnt[in_idx];
    end
  end

  // Stack and counter memory writes
  always_ff @(posedge clk) begin
    if (cmd.commit && req_in_range) begin
      if (local_push) begin
        local_stack[local_wr_addr] <= handle;
      end
      if (global_push) begin
        global_stack[global_wr_addr] <= handle;
      end
      local_cnt[idx]  <= lc_next;
      global_cnt[idx] <= gc_next;
    end
  end

  // Fill counts, counter row valid bits and depth limits
  always_ff @(posedge clk) begin
    if (rst) begin
      local_fill   <= '{default: '0};
      global_fill  <= '{default: '0};
      cnt_valid    <= '0;
      local_limit  <= LIMIT_RESET;
      global_limit <= LIMIT_RESET;
    end else begin
      if (cmd.commit && req_in_range) begin
        local_fill[idx]  <= lfill_next;
        global_fill[idx] <= gfill_next;
        cnt_valid[idx]   <= 1'b1;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_LOCAL_LIMIT) begin
          local_limit <= cfg_data;
        end else if (cfg_index == CFG_GLOBAL_LIMIT) begin
          global_limit <= cfg_data;
        end
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_in_range) begin
        out_data.result_handle       <= 32'(res_handle);
        out_data.route               <= route;
        out_data.local_alloc_total   <= lc_next.alloc_total;
        out_data.local_alloc_misses  <= lc_next.alloc_misses;
        out_data.local_free_total    <= lc_next.free_total;
        out_data.local_free_misses   <= lc_next.free_misses;
        out_data.global_alloc_total  <= gc_next.alloc_total;
        out_data.global_alloc_misses <= gc_next.alloc_misses;
        out_data.global_free_total   <= gc_next.free_total;
        out_data.global_free_misses  <= gc_next.free_misses;
      end else begin
        out_data <= pool_rsp;
      end
    end
  end

endmodule
